// ----- hw/rtl/pbrr_pkg.sv -----
// ----------------------------------------------------------------------------
// pbrr_pkg
// shared types and codes of the page buffer tag manager
// ----------------------------------------------------------------------------
package pbrr_pkg;

    localparam int SEG_W    = 32;
    localparam int OFFS_W   = 32;
    localparam int PAGE_W   = 19;
    localparam int POFF_W   = 13;
    localparam int UIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 7;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_APPEND = 2'd1,
        OP_UNPIN  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALL_PINNED = 3'd1,
        ST_UNPIN_ZERO = 3'd2,
        ST_BAD_INDEX  = 3'd3,
        ST_PIN_OVF    = 3'd4,
        ST_ZERO_SEG   = 3'd5
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

endpackage

// ----- hw/rtl/pbrr_datapath.sv -----
// ----------------------------------------------------------------------------
// pbrr_datapath
// tag store, associative match, rotating victim pick and entry update
// ----------------------------------------------------------------------------
module pbrr_datapath
    import pbrr_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int PAGE_BYTES = 8192,
    parameter int PIN_BITS   = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [CFG_W-1:0]    cfg_count,
    input  logic [1:0]          in_op,
    input  logic [SEG_W-1:0]    in_seg,
    input  logic [OFFS_W-1:0]   in_offs,
    input  logic [UIDX_W-1:0]   in_uidx,
    output logic                start_ok,
    output logic [UIDX_W-1:0]   res_index,
    output logic [POFF_W-1:0]   res_poff,
    output logic                res_hit,
    output logic                res_fill,
    output logic                res_wb,
    output logic [SEG_W-1:0]    res_vseg,
    output logic [PAGE_W-1:0]   res_vpage,
    output logic [STATUS_W-1:0] res_status
);

    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int PSHIFT = $clog2(PAGE_BYTES);
    localparam int LW     = PSHIFT;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    logic [SEG_W-1:0]    tag_seg_reg  [ENTRIES];
    logic [PAGE_W-1:0]   tag_page_reg [ENTRIES];
    logic [ENTRIES-1:0]  dirty_reg;
    logic [PIN_BITS-1:0] pin_reg      [ENTRIES];
    logic [IW-1:0]       ptr_reg;

    // scan start, the pointer reduced modulo the active count
    logic [IW-1:0]       start_reg;
    logic [CW-1:0]       n_seen_reg;

    // request latched in the first cycle
    logic [1:0]          op_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [LW-1:0]       poff_reg;
    logic [UIDX_W-1:0]   uidx_reg;
    logic [CW-1:0]       n_reg;
    logic                hit_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic                found_reg;
    logic [IW-1:0]       vic_reg;

    // active count, clamped to 1..ENTRIES
    logic [CW-1:0] n_now;
    always_comb
    begin
        if (cfg_count == '0)
            n_now = CW'(1);
        else if ({{(32-CFG_W){1'b0}}, cfg_count} > 32'(ENTRIES))
            n_now = CW'(ENTRIES);
        else
            n_now = CW'(cfg_count);
    end

    logic [PAGE_W-1:0] page_now;
    assign page_now = PAGE_W'(in_offs >> PSHIFT);

    // associative match, lowest entry wins
    logic           hit_now;
    logic [IW-1:0]  hit_idx_now;
    always_comb
    begin
        hit_now     = 1'b0;
        hit_idx_now = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if ((CW'(i) < n_now) && (tag_seg_reg[i] != '0) &&
                (tag_seg_reg[i] == in_seg) && (tag_page_reg[i] == page_now))
            begin
                hit_now     = 1'b1;
                hit_idx_now = IW'(i);
            end
        end
    end

    // rotating priority: first free entry at or after start, else first free
    logic [IW-1:0] start_now;
    logic          found_now;
    logic [IW-1:0] vic_now;
    logic          hi_found;
    logic [IW-1:0] hi_idx;
    logic          lo_found;
    logic [IW-1:0] lo_idx;
    always_comb
    begin
        start_now = start_reg;
        hi_found = 1'b0;
        hi_idx   = '0;
        lo_found = 1'b0;
        lo_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if ((CW'(i) < n_now) && (pin_reg[i] == '0))
            begin
                lo_found = 1'b1;
                lo_idx   = IW'(i);
                if (IW'(i) >= start_now)
                begin
                    hi_found = 1'b1;
                    hi_idx   = IW'(i);
                end
            end
        end
        found_now = lo_found;
        vic_now   = hi_found ? hi_idx : lo_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            seg_reg     <= in_seg;
            page_reg    <= page_now;
            poff_reg    <= in_offs[LW-1:0];
            uidx_reg    <= in_uidx;
            n_reg       <= n_now;
            hit_reg     <= hit_now;
            hit_idx_reg <= hit_idx_now;
            found_reg   <= found_now;
            vic_reg     <= vic_now;
        end
    end

    // second cycle: decide result and entry update
    logic [IW-1:0]  uidx_i;
    logic           uidx_ok;
    logic           wr_tag;
    logic           wr_pin;
    logic           wr_dirty;
    logic [IW-1:0]  wr_idx;
    logic [PIN_BITS-1:0] pin_new;
    logic           dirty_new;
    logic [IW-1:0]  ptr_next;
    logic           ptr_wr;
    logic [IW:0]    vic_inc;

    always_comb
    begin
        uidx_ok   = ({{(32-UIDX_W){1'b0}}, uidx_reg} < 32'(n_reg));
        uidx_i    = IW'(uidx_reg);
        wr_tag    = 1'b0;
        wr_pin    = 1'b0;
        wr_dirty  = 1'b0;
        wr_idx    = '0;
        pin_new   = '0;
        dirty_new = 1'b0;
        ptr_wr    = 1'b0;
        vic_inc   = {1'b0, vic_reg} + 1'b1;
        ptr_next  = (vic_inc >= (IW+1)'(n_reg)) ? '0 : vic_inc[IW-1:0];
        res_index  = '0;
        res_poff   = '0;
        res_hit    = 1'b0;
        res_fill   = 1'b0;
        res_wb     = 1'b0;
        res_vseg   = '0;
        res_vpage  = '0;
        res_status = ST_OK;
        case (op_t'(op_reg))
            OP_UNPIN:
            begin
                res_index = uidx_reg;
                if (!uidx_ok)
                    res_status = ST_BAD_INDEX;
                else if (pin_reg[uidx_i] == '0)
                    res_status = ST_UNPIN_ZERO;
                else
                begin
                    wr_pin  = 1'b1;
                    wr_idx  = uidx_i;
                    pin_new = pin_reg[uidx_i] - 1'b1;
                end
            end
            OP_READ, OP_APPEND:
            begin
                if (seg_reg == '0)
                    res_status = ST_ZERO_SEG;
                else if (hit_reg)
                begin
                    res_index = UIDX_W'(hit_idx_reg);
                    res_poff  = POFF_W'(poff_reg);
                    res_hit   = 1'b1;
                    wr_idx    = hit_idx_reg;
                    if (pin_reg[hit_idx_reg] == PIN_MAX)
                        res_status = ST_PIN_OVF;
                    else if (op_reg == OP_APPEND)
                    begin
                        wr_dirty  = 1'b1;
                        dirty_new = 1'b1;
                    end
                    else
                    begin
                        wr_pin  = 1'b1;
                        pin_new = pin_reg[hit_idx_reg] + 1'b1;
                    end
                end
                else if (!found_reg)
                    res_status = ST_ALL_PINNED;
                else
                begin
                    res_index = UIDX_W'(vic_reg);
                    res_poff  = POFF_W'(poff_reg);
                    res_fill  = 1'b1;
                    if ((tag_seg_reg[vic_reg] != '0) && dirty_reg[vic_reg])
                    begin
                        res_wb    = 1'b1;
                        res_vseg  = tag_seg_reg[vic_reg];
                        res_vpage = tag_page_reg[vic_reg];
                    end
                    wr_idx   = vic_reg;
                    wr_tag   = 1'b1;
                    wr_pin   = 1'b1;
                    wr_dirty = 1'b1;
                    ptr_wr   = 1'b1;
                    if (op_reg == OP_APPEND)
                    begin
                        dirty_new = 1'b1;
                        pin_new   = '0;
                    end
                    else
                    begin
                        dirty_new = 1'b0;
                        pin_new   = PIN_BITS'(1);
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_seg_reg[i]  <= '0;
                tag_page_reg[i] <= '0;
                pin_reg[i]      <= '0;
            end
            dirty_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_tag)
            begin
                tag_seg_reg[wr_idx]  <= seg_reg;
                tag_page_reg[wr_idx] <= page_reg;
            end
            if (wr_pin)
                pin_reg[wr_idx] <= pin_new;
            if (wr_dirty)
                dirty_reg[wr_idx] <= dirty_new;
            if (ptr_wr)
                ptr_reg <= ptr_next;
        end
    end

    // after a count change the start is reloaded from the pointer and
    // reduced by repeated subtraction; the pointer itself keeps its value
    assign start_ok = (n_seen_reg == n_now) && ({1'b0, start_reg} < (IW+1)'(n_now));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            n_seen_reg <= '0;
        end
        else if (cmd.commit && ptr_wr)
            start_reg <= ptr_next;
        else if (n_seen_reg != n_now)
        begin
            start_reg  <= ptr_reg;
            n_seen_reg <= n_now;
        end
        else if (!start_ok)
            start_reg <= IW'({1'b0, start_reg} - (IW+1)'(n_now));
    end

endmodule

// ----- hw/rtl/pbrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbrr_ctrl
// request sequencer and output word register
// ----------------------------------------------------------------------------
module pbrr_ctrl
    import pbrr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start_ok,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic    out_load,
    output dp_cmd_t cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // a new request may enter while the last word still waits
    assign s_tready = (state_reg == S_IDLE) && start_ok;
    assign m_tvalid = mvalid_reg;
    assign cmd.load = s_tvalid && s_tready;
    // commit only when the output register is free to take the word
    assign cmd.commit = (state_reg == S_EXEC) && (!mvalid_reg || m_tready);
    assign out_load = cmd.commit;

    always_comb
    begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next  = S_IDLE;
                    mvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ----- hw/rtl/page_buffer_pin_and_round_robin_evict.sv -----
// ----------------------------------------------------------------------------
// page_buffer_pin_and_round_robin_evict
// tag manager for a fully associative page buffer with pin counts
// ----------------------------------------------------------------------------
// Each request word is first matched against the tags of all entries in use
// while a round-robin victim is picked among unpinned entries; then the
// chosen entry is updated and the result register loaded, once that register
// is free to take the word. A new word is taken only after the last one has
// been committed; the result register lets the next request start while a
// result still waits. After a change of the entry count the input holds off
// while the victim scan start is reduced modulo the new count.
module page_buffer_pin_and_round_robin_evict
    import pbrr_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int PAGE_BYTES = 8192,
    parameter int PIN_BITS   = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // opcode[1:0], segment_number[33:2], segment_byte_offset[65:34],
    // unpin_index[71:66]
    input  logic [71:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // entry_index[5:0], in_page_offset[18:6], was_hit[19], fill_request[20],
    // writeback_request[21], victim_segment[53:22], victim_page[72:54],
    // status[75:73]
    output logic [79:0]       m_tdata
);

    logic [CFG_W-1:0] cfg_reg;
    dp_cmd_t          cmd;
    logic             out_load;
    logic             start_ok;
    logic [75:0]      res;
    logic [75:0]      out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_W'(64);
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    pbrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start_ok (start_ok),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    pbrr_datapath #(
        .ENTRIES    (ENTRIES),
        .PAGE_BYTES (PAGE_BYTES),
        .PIN_BITS   (PIN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_count  (cfg_reg),
        .in_op      (s_tdata[1:0]),
        .in_seg     (s_tdata[33:2]),
        .in_offs    (s_tdata[65:34]),
        .in_uidx    (s_tdata[71:66]),
        .start_ok   (start_ok),
        .res_index  (res[5:0]),
        .res_poff   (res[18:6]),
        .res_hit    (res[19]),
        .res_fill   (res[20]),
        .res_wb     (res[21]),
        .res_vseg   (res[53:22]),
        .res_vpage  (res[72:54]),
        .res_status (res[75:73])
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res;
    end

    assign m_tdata = {4'b0, out_reg};

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// request stream test of the page buffer tag manager: a local model of the
// tags, pin counts and victim pointer predicts each result word, checked in
// order against the output stream under random bursts and output stalls
// ----------------------------------------------------------------------------
module tb_top;
    import pbrr_pkg::*;

    localparam int NENT    = 64;
    localparam int PBYTES  = 8192;
    localparam int PINMAX  = 65535;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [5:0]  uidx;
        logic [31:0] offs;
        logic [31:0] seg;
        op_t         op;
    } req_t;

    typedef struct packed {
        logic [3:0]  pad;
        status_t     status;
        logic [18:0] vpage;
        logic [31:0] vseg;
        logic        wb;
        logic        fill;
        logic        hit;
        logic [12:0] poff;
        logic [5:0]  idx;
    } rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    page_buffer_pin_and_round_robin_evict uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // buffer model
    logic [31:0] mdl_seg [NENT];
    logic [18:0] mdl_page [NENT];
    logic        mdl_dirty [NENT];
    int unsigned mdl_pins [NENT];
    int unsigned mdl_ptr;
    int unsigned mdl_count_reg;

    req_t   pending_words[$];
    rsp_t   expected_rsp[$];
    int     errors;
    int     mismatches;
    longint cycles;
    bit     hold_off;
    int     hold_cnt;
    bit     accepted;

    function automatic rsp_t lookup_page(req_t r);
        rsp_t        o;
        int unsigned n;
        int unsigned c;
        logic [18:0] pg;
        bit          found;
        o = '0;
        n = mdl_count_reg;
        if (n < 1) n = 1;
        if (n > NENT) n = NENT;
        pg = 19'(r.offs / PBYTES);
        if (r.op == OP_NONE) return o;
        if (r.op == OP_UNPIN) begin
            o.idx = r.uidx;
            if (r.uidx >= n) o.status = ST_BAD_INDEX;
            else if (mdl_pins[r.uidx] == 0) o.status = ST_UNPIN_ZERO;
            else mdl_pins[r.uidx]--;
            return o;
        end
        if (r.seg == 0) begin
            o.status = ST_ZERO_SEG;
            return o;
        end
        for (int i = 0; i < n; i++) begin
            if (mdl_seg[i] != 0 && mdl_seg[i] == r.seg && mdl_page[i] == pg) begin
                o.idx = 6'(i);
                o.poff = 13'(r.offs % PBYTES);
                o.hit = 1'b1;
                if (mdl_pins[i] >= PINMAX) o.status = ST_PIN_OVF;
                else if (r.op == OP_APPEND) mdl_dirty[i] = 1'b1;
                else mdl_pins[i]++;
                return o;
            end
        end
        found = 0;
        c = 0;
        for (int i = 0; i < n; i++) begin
            c = (mdl_ptr % n + i) % n;
            if (mdl_pins[c] == 0) begin
                found = 1;
                break;
            end
        end
        if (!found) begin
            o.status = ST_ALL_PINNED;
            return o;
        end
        mdl_ptr = (c + 1) % n;
        if (mdl_seg[c] != 0 && mdl_dirty[c]) begin
            o.wb = 1'b1;
            o.vseg = mdl_seg[c];
            o.vpage = mdl_page[c];
        end
        mdl_seg[c] = r.seg;
        mdl_page[c] = pg;
        mdl_dirty[c] = (r.op == OP_APPEND);
        mdl_pins[c] = (r.op == OP_APPEND) ? 0 : 1;
        o.idx = 6'(c);
        o.poff = 13'(r.offs % PBYTES);
        o.fill = 1'b1;
        return o;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // input words are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) begin
            expected_rsp.push_back(lookup_page(req_t'(s_tdata)));
            accepted = 1'b1;
        end
    end

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || accepted)) begin
            accepted = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_tdata <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (hold_off) begin
            hold_off = 0;
            hold_cnt = 300;
            m_tready <= 1'b0;
        end else if (cycles % 1000 < 400) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready) begin
            rsp_t got;
            rsp_t want;
            got = rsp_t'(m_tdata);
            if (expected_rsp.size() == 0) begin
                errors++;
                $display("unexpected result word %h", m_tdata);
            end else begin
                want = expected_rsp.pop_front();
                if (got[75:0] !== want[75:0]) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp idx %0d off %0d hit %b fill %b wb %b ",
                                  "vseg %h vpg %h st %0d / got idx %0d off %0d hit %b ",
                                  "fill %b wb %b vseg %h vpg %h st %0d"},
                            want.idx, want.poff, want.hit, want.fill, want.wb, want.vseg,
                            want.vpage, want.status, got.idx, got.poff, got.hit,
                            got.fill, got.wb, got.vseg, got.vpage, got.status);
                end
            end
        end
    end

    function automatic req_t mk(op_t op, logic [31:0] seg, logic [31:0] offs,
                                logic [5:0] ui);
        req_t r;
        r.op = op;
        r.seg = seg;
        r.offs = offs;
        r.uidx = ui;
        return r;
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_count(int unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 7'(v);
        mdl_count_reg = v & 7'h7f;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly a small working set so hits, evictions and unpins mix
    task automatic random_phase(int cnt, int nseg);
        req_t r;
        int   k;
        for (int i = 0; i < cnt; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) r = mk(OP_READ, 32'($urandom_range(1, nseg)),
                               32'($urandom_range(0, 5) * PBYTES + $urandom_range(0, 8191)),
                               6'd0);
            else if (k < 60) r = mk(OP_APPEND, 32'($urandom_range(1, nseg)),
                                    32'($urandom_range(0, 5) * PBYTES + $urandom),
                                    6'($urandom));
            else if (k < 90) r = mk(OP_UNPIN, $urandom, $urandom,
                                    6'($urandom_range(0, 3) ? $urandom_range(0, 15)
                                                            : $urandom));
            else if (k < 95) r = mk(op_t'($urandom_range(0, 3)), $urandom, $urandom,
                                    6'($urandom));
            else r = mk(op_t'($urandom_range(0, 1)), 32'd0, $urandom, 6'($urandom));
            pending_words.push_back(r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        mismatches = 0;
        cycles = 0;
        hold_off = 0;
        hold_cnt = 0;
        accepted = 0;
        burst_left = 0;
        gap_left = 0;
        mdl_ptr = 0;
        mdl_count_reg = 64;
        for (int i = 0; i < NENT; i++)
        begin
            mdl_seg[i] = 0;
            mdl_page[i] = 0;
            mdl_dirty[i] = 0;
            mdl_pins[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero segment, no-op and unpins of unpinned entries
        pending_words.push_back(mk(OP_READ, 32'hffffffff, 32'hffffffff, 6'd0));
        pending_words.push_back(mk(OP_APPEND, 32'hffffffff, 32'hffffffff, 6'h3f));
        pending_words.push_back(mk(OP_READ, 32'd0, 32'h1234, 6'd0));
        pending_words.push_back(mk(OP_APPEND, 32'd0, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_NONE, 32'hffffffff, 32'hffffffff, 6'h3f));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd1));
        // page number is offset bits 31:13: offset 0 gives page 0, 2^32-8192 page 2^19-1
        pending_words.push_back(mk(OP_APPEND, 32'd7, 32'h0, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd7, 32'h1, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd9, 32'hffffe000, 6'd0));
        drain();

        // one entry (a count of 0 clamps to 1), then two: fill, pin, all pinned, bad index, writeback
        set_count(0);
        pending_words.push_back(mk(OP_APPEND, 32'd3, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_APPEND, 32'd4, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd5, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd1));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd0));
        drain();
        set_count(2);
        pending_words.push_back(mk(OP_APPEND, 32'd3, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd4, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd6, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_READ, 32'd8, 32'd0, 6'd0));
        pending_words.push_back(mk(OP_UNPIN, 32'd0, 32'd0, 6'd2));
        drain();

        set_count(127);
        hold_off = 1;
        random_phase(600, 40);
        drain();
        set_count(8);
        random_phase(500, 12);
        drain();
        set_count(64);
        random_phase(600, 100);
        drain();
        set_count(3);
        random_phase(300, 6);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pbrr_pkg.sv
hw/rtl/pbrr_datapath.sv
hw/rtl/pbrr_ctrl.sv
hw/rtl/page_buffer_pin_and_round_robin_evict.sv
test/tb_top.sv
